// File: src/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion helpers for the RTL; empty in synthesis.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked every cycle outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: src/sths_pkg.sv
// ============================================================================
// sths_pkg
// Types and constants of the sparse tiled heightfield store.
// ============================================================================
`default_nettype none
package sths_pkg;
  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_BILIN  = 2'd2;

  localparam logic [1:0] REG_ACROSS = 2'd0;
  localparam logic [1:0] REG_DOWN   = 2'd1;
  localparam logic [1:0] REG_SIDE   = 2'd2;
  localparam logic [1:0] REG_BASE   = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
    logic [15:0]        write_value;
  } sths_in_t;

  typedef struct packed {
    logic [15:0] sample_value;
    logic [31:0] interp_value;
    logic        write_taken;
    logic        tile_created;
  } sths_out_t;
endpackage
`default_nettype wire

// File: src/sparse_tiled_heightfield_store.sv
// ============================================================================
// sparse_tiled_heightfield_store
// Sparse tiled heightfield with sample read, write and bilinear sampling.
// ============================================================================
// One item is worked at a time by a small sequencer around one shared
// subtract/compare unit and one 25x9 multiplier. A coordinate's integer part
// is clamped, then split into tile index and offset by repeated subtraction of
// the tile side, and the offset row is formed by repeated addition, so the
// time a read takes is set by the tile column, the tile row and the row offset
// of the sample. A bilinear read repeats the lookup for each of its four
// corners and then weights the four samples in the shared multiplier. A write
// that lies outside the field stores nothing, and the first write into an
// absent tile fills it with the base sample, one memory word per cycle, before
// it stores. An unknown operation skips the lookup and goes straight to its
// result. Results wait in an output register, and input is stalled while an
// item is at work or its result still waits for that register.
// Writing any geometry register makes every tile absent at once.
`default_nettype none
`include "assert_macros.svh"
module sparse_tiled_heightfield_store
  import sths_pkg::*;
#(
  parameter int MAX_TILES_PER_AXIS = 4,
  parameter int MAX_TILE_SIDE = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire sths_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output sths_out_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int TW = $clog2(MAX_TILES_PER_AXIS + 1);
  localparam int SW = $clog2(MAX_TILE_SIDE + 1);
  localparam int NT = MAX_TILES_PER_AXIS * MAX_TILES_PER_AXIS;
  localparam int TIW = (NT > 1) ? $clog2(NT) : 1;
  localparam int OW = (MAX_TILE_SIDE > 1) ? $clog2(MAX_TILE_SIDE) : 1;
  localparam int SLW = (MAX_TILE_SIDE * MAX_TILE_SIDE > 1) ?
                       $clog2(MAX_TILE_SIDE * MAX_TILE_SIDE) : 1;
  localparam int AW = TIW + SLW;
  localparam int DEPTH = NT * MAX_TILE_SIDE * MAX_TILE_SIDE;
  localparam int CW = 26;

  typedef enum logic [3:0] {
    S_IDLE, S_CLAMP, S_DIVX, S_DIVY, S_ROW, S_LOOK, S_RDWAIT, S_FILL,
    S_STORE, S_MUL, S_DONE
  } state_t;

  state_t state;
  logic [2:0]  tiles_across, tiles_down;
  logic [5:0]  tile_side;
  logic [15:0] base_sample;
  logic [NT-1:0] tile_resident;

  sths_in_t    item;
  logic [1:0]  corner;
  logic signed [CW-1:0] px, py;
  logic [TW-1:0] tx, ty;
  logic [OW-1:0] ox, oy;
  logic [SLW-1:0] row, fill_idx;
  logic [OW-1:0]  row_cnt;
  logic [15:0] h [4];
  logic [2:0]  mstep;
  logic [40:0] acc, top;
  logic        created;
  logic        outside;

  logic [15:0] mem [DEPTH];
  logic [15:0] mem_q;

  // Effective geometry after clamping of out-of-range register values.
  logic [TW-1:0] eff_across, eff_down;
  logic [SW-1:0] eff_side;
  logic [CW-1:0] w_samp, h_samp;
  always_comb begin
    eff_across = (tiles_across == 3'd0) ? TW'(1) :
      (32'(tiles_across) > MAX_TILES_PER_AXIS) ? TW'(MAX_TILES_PER_AXIS) : TW'(tiles_across);
    eff_down = (tiles_down == 3'd0) ? TW'(1) :
      (32'(tiles_down) > MAX_TILES_PER_AXIS) ? TW'(MAX_TILES_PER_AXIS) : TW'(tiles_down);
    eff_side = (tile_side == 6'd0) ? SW'(1) :
      (32'(tile_side) > MAX_TILE_SIDE) ? SW'(MAX_TILE_SIDE) : SW'(tile_side);
    w_samp = CW'(eff_across) * CW'(eff_side);
    h_samp = CW'(eff_down) * CW'(eff_side);
  end

  logic signed [CW-1:0] ix, iy;
  logic [7:0] fx, fy;
  assign ix = CW'(item.coord_x >>> 8) + ((corner[0]) ? CW'(1) : CW'(0));
  assign iy = CW'(item.coord_y >>> 8) + ((corner[1]) ? CW'(1) : CW'(0));
  assign fx = item.coord_x[7:0];
  assign fy = item.coord_y[7:0];

  logic [TIW-1:0] tidx;
  logic [AW-1:0]  addr;
  assign tidx = TIW'(TIW'(ty) * TIW'(eff_across) + TIW'(tx));
  assign addr = {tidx, SLW'(row + SLW'(ox))};

  // Shared multiplier: 25-bit by 9-bit operands, one product per cycle. The
  // first four steps weight the corners along x, the last two weight the two
  // row sums along y.
  logic [24:0] m_a;
  logic [8:0]  m_b;
  logic [33:0] m_p;
  always_comb begin
    case (mstep)
      3'd0: begin m_a = 25'(h[0]); m_b = 9'd256 - 9'(fx); end
      3'd1: begin m_a = 25'(h[1]); m_b = 9'(fx); end
      3'd2: begin m_a = 25'(h[2]); m_b = 9'd256 - 9'(fx); end
      3'd3: begin m_a = 25'(h[3]); m_b = 9'(fx); end
      3'd4: begin m_a = top[24:0]; m_b = 9'd256 - 9'(fy); end
      3'd5: begin m_a = acc[24:0]; m_b = 9'(fy); end
      default: begin m_a = '0; m_b = '0; end
    endcase
    m_p = 34'(m_a) * 34'(m_b);
  end

  logic mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0] mem_wd;
  always_comb begin
    mem_we = 1'b0; mem_wa = addr; mem_wd = item.write_value;
    if (state == S_FILL) begin
      mem_we = 1'b1; mem_wa = {tidx, fill_idx}; mem_wd = base_sample;
    end else if (state == S_STORE) begin
      mem_we = 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[addr];
  end

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[3:2])
      REG_ACROSS: prdata = 32'(tiles_across);
      REG_DOWN:   prdata = 32'(tiles_down);
      REG_SIDE:   prdata = 32'(tile_side);
      REG_BASE:   prdata = 32'(base_sample);
      default:    prdata = '0;
    endcase
  end
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0;
      tiles_across <= 3'd1; tiles_down <= 3'd1; tile_side <= 6'd32;
      base_sample <= '0; tile_resident <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_ACROSS: begin tiles_across <= pwdata[2:0]; tile_resident <= '0; end
          REG_DOWN:   begin tiles_down <= pwdata[2:0]; tile_resident <= '0; end
          REG_SIDE:   begin tile_side <= pwdata[5:0]; tile_resident <= '0; end
          REG_BASE:   base_sample <= pwdata[15:0];
          default: ;
        endcase
      end
      // A finished item reloads the output register itself in S_DONE.
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) begin
          item <= in_data; corner <= '0; mstep <= '0; created <= 1'b0;
          state <= (in_data.operation == OP_READ || in_data.operation == OP_WRITE ||
                    in_data.operation == OP_BILIN) ? S_CLAMP : S_DONE;
        end
        S_CLAMP: begin
          outside <= ix < 0 || iy < 0 || ix >= $signed(w_samp) || iy >= $signed(h_samp);
          px <= (ix < 0) ? '0 : (ix >= $signed(w_samp)) ? $signed(w_samp - CW'(1)) : ix;
          py <= (iy < 0) ? '0 : (iy >= $signed(h_samp)) ? $signed(h_samp - CW'(1)) : iy;
          tx <= '0; ty <= '0; row <= '0; row_cnt <= '0; fill_idx <= '0;
          state <= S_DIVX;
        end
        S_DIVX: if (px >= $signed(CW'(eff_side))) begin
          px <= px - $signed(CW'(eff_side)); tx <= tx + 1'b1;
        end else begin
          ox <= OW'(px); state <= S_DIVY;
        end
        S_DIVY: if (py >= $signed(CW'(eff_side))) begin
          py <= py - $signed(CW'(eff_side)); ty <= ty + 1'b1;
        end else begin
          oy <= OW'(py); state <= S_ROW;
        end
        S_ROW: if (row_cnt != oy) begin
          row <= row + SLW'(eff_side); row_cnt <= row_cnt + 1'b1;
        end else begin
          state <= (item.operation == OP_WRITE) ?
            (outside ? S_DONE : (tile_resident[tidx] ? S_STORE : S_FILL)) : S_LOOK;
        end
        S_LOOK: state <= S_RDWAIT;
        S_RDWAIT: begin
          h[corner] <= tile_resident[tidx] ? mem_q : base_sample;
          if (item.operation == OP_BILIN && corner != 2'd3) begin
            corner <= corner + 1'b1; state <= S_CLAMP;
          end else begin
            acc <= '0; state <= (item.operation == OP_BILIN) ? S_MUL : S_DONE;
          end
        end
        S_FILL: begin
          fill_idx <= fill_idx + 1'b1;
          if (32'(fill_idx) + 1 >= 32'(eff_side) * 32'(eff_side)) begin
            tile_resident[tidx] <= 1'b1; created <= 1'b1; state <= S_STORE;
          end
        end
        S_STORE: state <= S_DONE;
        S_MUL: begin
          mstep <= mstep + 1'b1;
          // top collects the upper row sum, acc the lower one; the last two
          // steps weight them along y and add.
          case (mstep)
            3'd0, 3'd2: acc <= 41'(m_p);
            3'd1: top <= acc + 41'(m_p);
            3'd3: acc <= acc + 41'(m_p);
            3'd4: top <= 41'(m_p);
            default: begin acc <= top + 41'(m_p); state <= S_DONE; end
          endcase
        end
        S_DONE: if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
          out_data.sample_value <= (item.operation == OP_READ) ? h[0] : 16'd0;
          out_data.interp_value <= (item.operation == OP_BILIN) ? acc[31:0] : 32'd0;
          out_data.write_taken <= (item.operation == OP_WRITE) && !outside;
          out_data.tile_created <= (item.operation == OP_WRITE) && created;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_stall_busy, clk, rst, state != S_IDLE, in_stall)
  `ASSERT_IMPL(a_created_taken, clk, rst, out_valid && out_data.tile_created, out_data.write_taken)
  `ASSERT_NEXT(a_fill_resident, clk, rst, state == S_STORE && created, tile_resident != '0)
endmodule
`default_nettype wire
